[rtl/assert_macros.svh]
// ----------------------------------------------------------------------------
// assertion macros
// shared concurrent assertion forms for the checker files
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// consequent must hold in the same cycle as the antecedent
`define ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: same-cycle check");

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: next-cycle check");

`endif

[rtl/b2da_pkg.sv]
// ----------------------------------------------------------------------------
// b2da_pkg
// types and constants shared by the decimal text converter
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package b2da_pkg;

   localparam int REQ_DATA_W  = 64;
   localparam int RSP_DATA_W  = 16;
   localparam int TEXT_CHAR_W = 6;
   localparam int TEXT_LEN_W  = 5;
   localparam int BCD_DIGIT_W = 4;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [TEXT_CHAR_W-1:0] CHAR_ZERO  = 6'd48;
   localparam logic [TEXT_CHAR_W-1:0] CHAR_NINE  = 6'd57;
   localparam logic [TEXT_CHAR_W-1:0] CHAR_MINUS = 6'd45;

   // shift-and-add-3 correction
   localparam logic [BCD_DIGIT_W-1:0] DABBLE_LIMIT = 4'd5;
   localparam logic [BCD_DIGIT_W-1:0] DABBLE_ADD   = 4'd3;

   typedef enum logic [2:0] {
      ST_IDLE = 3'b001,
      ST_CONV = 3'b010,
      ST_EMIT = 3'b100
   } back_state_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   // decimal digits of 2^bits - 1, using log10(2) ~ 0.30103
   function automatic int decimal_digits(input int bits);
      return (bits * 30103) / 100000 + 1;
   endfunction

endpackage

[rtl/b2da_front.sv]
// ----------------------------------------------------------------------------
// b2da_front
// accepts requests, resolves sign and magnitude, pushes into the queue
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module b2da_front
   import b2da_pkg::*;
#(
   parameter int VALUE_WIDTH = 64
) (
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_DATA_W-1:0]  req_tdata,
   input  logic                   req_tuser,
   input  queue_status_type       status,
   output logic                   push,
   output logic [VALUE_WIDTH:0]   push_data
);

   logic [VALUE_WIDTH-1:0] value;
   logic [VALUE_WIDTH-1:0] magnitude;
   logic                   negative;

   always_comb begin
      value    = req_tdata[VALUE_WIDTH-1:0];
      negative = req_tuser & value[VALUE_WIDTH-1];
      // most negative value wraps onto itself, read as unsigned it is right
      magnitude = negative ? (~value + VALUE_WIDTH'(1)) : value;
   end

   assign req_tready = ~status.full;
   assign push       = req_tvalid & ~status.full;
   assign push_data  = {negative, magnitude};

endmodule

[rtl/b2da_queue.sv]
// ----------------------------------------------------------------------------
// b2da_queue
// short register queue between the front and back ends
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module b2da_queue
   import b2da_pkg::*;
#(
   parameter int WIDTH = 65
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output queue_status_type status
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   logic [WIDTH-1:0] entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   function automatic logic [PTR_W-1:0] next_ptr(input logic [PTR_W-1:0] ptr);
      return (ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : ptr + PTR_W'(1);
   endfunction

   always_comb begin
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop  ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data     = entry_ff[rd_ptr_ff];
   assign status.full  = (count_ff == CNT_W'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);

endmodule

[rtl/b2da_back.sv]
// ----------------------------------------------------------------------------
// b2da_back
// bit-serial binary to bcd conversion and character emission
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module b2da_back
   import b2da_pkg::*;
#(
   parameter int VALUE_WIDTH = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  queue_status_type      status,
   output logic                  pop,
   input  logic [VALUE_WIDTH:0]  pop_data,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic                  rsp_tlast
);

   localparam int NUM_DIGITS  = decimal_digits(VALUE_WIDTH);
   localparam int DIGIT_IDX_W = $clog2(NUM_DIGITS);
   localparam int BIT_CNT_W   = $clog2(VALUE_WIDTH);
   localparam int PAD_W       = RSP_DATA_W - TEXT_LEN_W - TEXT_CHAR_W;

   back_state_type state_ff, state_in;

   logic [VALUE_WIDTH-1:0]                  shift_ff, shift_in;
   logic [NUM_DIGITS-1:0][BCD_DIGIT_W-1:0]  bcd_ff, bcd_in;
   logic [TEXT_LEN_W-1:0]                   len_ff, len_in;
   logic [TEXT_LEN_W-1:0]                   total_ff, total_in;
   logic [DIGIT_IDX_W-1:0]                  ptr_ff, ptr_in;
   logic [BIT_CNT_W-1:0]                    bit_cnt_ff, bit_cnt_in;
   logic                                    neg_ff, neg_in;
   logic                                    sign_pending_ff, sign_pending_in;

   logic                   out_valid_ff, out_valid_in;
   logic [TEXT_CHAR_W-1:0] out_char_ff, out_char_in;
   logic                   out_last_ff, out_last_in;
   logic [TEXT_LEN_W-1:0]  out_len_ff, out_len_in;

   logic [NUM_DIGITS-1:0][BCD_DIGIT_W-1:0]  bcd_adj;
   logic [NUM_DIGITS*BCD_DIGIT_W-1:0]       bcd_adj_flat;
   logic [NUM_DIGITS-1:0][BCD_DIGIT_W-1:0]  bcd_step;
   logic [TEXT_LEN_W-1:0]                   len_step;
   logic                                    grow;
   logic                                    out_free;

   // one dabble step: correct each digit, then shift in the next bit
   always_comb begin
      for (int d = 0; d < NUM_DIGITS; d++) begin
         bcd_adj[d] = (bcd_ff[d] >= DABBLE_LIMIT) ? bcd_ff[d] + DABBLE_ADD : bcd_ff[d];
      end
      bcd_adj_flat = bcd_adj;
      bcd_step     = {bcd_adj_flat[NUM_DIGITS*BCD_DIGIT_W-2:0], shift_ff[VALUE_WIDTH-1]};
      // doubling adds at most one digit, so only the next digit up is checked
      grow = (len_ff < TEXT_LEN_W'(NUM_DIGITS)) &&
             (bcd_step[len_ff[DIGIT_IDX_W-1:0]] != '0);
      len_step = len_ff + TEXT_LEN_W'(grow);
   end

   assign out_free = ~out_valid_ff | rsp_tready;
   assign pop      = (state_ff == ST_IDLE) & ~status.empty;

   always_comb begin
      state_in        = state_ff;
      shift_in        = shift_ff;
      bcd_in          = bcd_ff;
      len_in          = len_ff;
      total_in        = total_ff;
      ptr_in          = ptr_ff;
      bit_cnt_in      = bit_cnt_ff;
      neg_in          = neg_ff;
      sign_pending_in = sign_pending_ff;
      out_valid_in    = out_valid_ff & ~rsp_tready;
      out_char_in     = out_char_ff;
      out_last_in     = out_last_ff;
      out_len_in      = out_len_ff;

      case (state_ff)
         ST_IDLE: begin
            if (!status.empty) begin
               shift_in   = pop_data[VALUE_WIDTH-1:0];
               neg_in     = pop_data[VALUE_WIDTH];
               bcd_in     = '0;
               len_in     = TEXT_LEN_W'(1);
               bit_cnt_in = '0;
               state_in   = ST_CONV;
            end
         end
         ST_CONV: begin
            bcd_in     = bcd_step;
            len_in     = len_step;
            shift_in   = shift_ff << 1;
            bit_cnt_in = bit_cnt_ff + BIT_CNT_W'(1);
            if (bit_cnt_ff == BIT_CNT_W'(VALUE_WIDTH - 1)) begin
               ptr_in          = DIGIT_IDX_W'(len_step - TEXT_LEN_W'(1));
               total_in        = len_step + TEXT_LEN_W'(neg_ff);
               sign_pending_in = neg_ff;
               state_in        = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_len_in   = total_ff;
               if (sign_pending_ff) begin
                  out_char_in     = CHAR_MINUS;
                  out_last_in     = 1'b0;
                  sign_pending_in = 1'b0;
               end else begin
                  out_char_in = CHAR_ZERO + TEXT_CHAR_W'(bcd_ff[ptr_ff]);
                  out_last_in = (ptr_ff == '0);
                  if (ptr_ff == '0) begin
                     state_in = ST_IDLE;
                  end else begin
                     ptr_in = ptr_ff - DIGIT_IDX_W'(1);
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      shift_ff        <= shift_in;
      bcd_ff          <= bcd_in;
      len_ff          <= len_in;
      total_ff        <= total_in;
      ptr_ff          <= ptr_in;
      bit_cnt_ff      <= bit_cnt_in;
      neg_ff          <= neg_in;
      sign_pending_ff <= sign_pending_in;
      out_char_ff     <= out_char_in;
      out_last_ff     <= out_last_in;
      out_len_ff      <= out_len_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tdata  = {{PAD_W{1'b0}}, out_len_ff, out_char_ff};

endmodule

[rtl/binary_to_decimal_ascii.sv]
// ----------------------------------------------------------------------------
// binary_to_decimal_ascii
// prints a signed or unsigned binary word as decimal ascii text
// ----------------------------------------------------------------------------
//
//  channel   dir   tdata                                  tuser / tlast
//  req       in    [63:0] value_bits                      tuser: is_signed
//  rsp       out   [5:0] text_char, [10:6] text_length    tlast: is_last
//
//  each number is loaded, then runs through the shift-add-3 loop of the back end
//  bit by bit, then goes out one character per cycle while rsp is not stalled (up to 20)
//  the front end keeps taking requests into a two-entry queue meanwhile
//  a stalled rsp holds its character; the back end waits on the output register
//  reset clears the queue pointers, the back end state and the output valid
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module binary_to_decimal_ascii
   import b2da_pkg::*;
#(
   parameter int VALUE_WIDTH = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [REQ_DATA_W-1:0] req_tdata,   // [63:0] value_bits
   input  logic                  req_tuser,   // [0] is_signed
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // [5:0] text_char, [10:6] text_length
   output logic                  rsp_tlast
);

   queue_status_type     status;
   logic                 push;
   logic                 pop;
   logic [VALUE_WIDTH:0] push_data;
   logic [VALUE_WIDTH:0] pop_data;

   b2da_front #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .status     (status),
      .push       (push),
      .push_data  (push_data)
   );

   b2da_queue #(
      .WIDTH (VALUE_WIDTH + 1)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .status    (status)
   );

   b2da_back #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .status     (status),
      .pop        (pop),
      .pop_data   (pop_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

endmodule

[rtl/b2da_checker.sv]
// ----------------------------------------------------------------------------
// b2da_checker
// port-level checks on the response stream of the converter
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module b2da_checker
   import b2da_pkg::*;
(
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_tvalid,
   input logic                  rsp_tready,
   input logic [RSP_DATA_W-1:0] rsp_tdata,
   input logic                  rsp_tlast
);

   logic [TEXT_CHAR_W-1:0] rsp_char;
   logic [TEXT_LEN_W-1:0]  rsp_len;
   logic [RSP_DATA_W:0]    rsp_word;
   logic                   rsp_stall;
   logic                   rsp_mid;
   logic                   rsp_digit;
   logic                   char_ok;

   assign rsp_char  = rsp_tdata[TEXT_CHAR_W-1:0];
   assign rsp_len   = rsp_tdata[TEXT_CHAR_W+TEXT_LEN_W-1:TEXT_CHAR_W];
   assign rsp_word  = {rsp_tlast, rsp_tdata};
   assign rsp_stall = rsp_tvalid && !rsp_tready;
   assign rsp_mid   = rsp_tvalid && rsp_tready && !rsp_tlast;
   assign rsp_digit = (rsp_char != CHAR_MINUS);
   assign char_ok   = (rsp_char == CHAR_MINUS) ||
                      (rsp_char >= CHAR_ZERO && rsp_char <= CHAR_NINE);

   // stalled response holds
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_tvalid && $stable(rsp_word))

   // only a minus or a digit, and a non-zero length
   `ASSERT_NOW(a_char_legal, clock, reset, rsp_tvalid, char_ok && rsp_len != '0)

   // a number never ends on its sign
   `ASSERT_NOW(a_minus_not_last, clock, reset, rsp_tvalid && rsp_tlast, rsp_digit)

   // within one number the length stays put and no second sign shows up
   `ASSERT_NEXT(a_number, clock, reset, rsp_mid, !rsp_tvalid || ($stable(rsp_len) && rsp_digit))

endmodule

bind binary_to_decimal_ascii b2da_checker u_checker (.*);
